// ----- rtl/avg_pkg.sv -----
// ---------------------------------------------------------------------------
// avg_pkg
// Shared types, command codes and constants of the arc vertex generator.
// ---------------------------------------------------------------------------
`default_nettype none

package avg_pkg;

   localparam int MaxSegments = 62;

   // CORDIC start magnitude, 1/K in Q1.30
   localparam logic signed [33:0] CordicGain = 34'sd652032874;
   localparam int CordicSteps = 30;

   // datapath operations
   localparam logic [4:0] OP_NOP          = 5'd0;
   localparam logic [4:0] OP_LOAD         = 5'd1;
   localparam logic [4:0] OP_MUL100       = 5'd2;
   localparam logic [4:0] OP_QLOAD        = 5'd3;
   localparam logic [4:0] OP_SQRT         = 5'd4;
   localparam logic [4:0] OP_MULN         = 5'd5;
   localparam logic [4:0] OP_SEGS         = 5'd6;
   localparam logic [4:0] OP_DIVINIT      = 5'd7;
   localparam logic [4:0] OP_DIV          = 5'd8;
   localparam logic [4:0] OP_CINIT_STEP   = 5'd9;
   localparam logic [4:0] OP_CINIT_START  = 5'd10;
   localparam logic [4:0] OP_CORDIC       = 5'd11;
   localparam logic [4:0] OP_CSTORE_STEP  = 5'd12;
   localparam logic [4:0] OP_CSTORE_START = 5'd13;
   localparam logic [4:0] OP_MULRX        = 5'd14;
   localparam logic [4:0] OP_ROTX         = 5'd15;
   localparam logic [4:0] OP_MULRY        = 5'd16;
   localparam logic [4:0] OP_ROTY         = 5'd17;
   localparam logic [4:0] OP_CENTRE       = 5'd18;
   localparam logic [4:0] OP_VERTEX       = 5'd19;
   localparam logic [4:0] OP_MAC          = 5'd20;
   localparam logic [4:0] OP_ROTUPD       = 5'd21;
   localparam logic [4:0] OP_LOOP         = 5'd22;

   typedef struct packed {
      logic [4:0] op;
      logic [5:0] idx;
   } cmd_type;

   typedef struct packed {
      logic auto_seg;
      logic include_centre;
      logic close_loop;
      logic left_one;
   } status_type;

   // atan(2^-i) in 32-bit turns
   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] v;
      begin
         unique case (i)
            5'd0: v = 32'h20000000;   5'd1: v = 32'h12E4051E;
            5'd2: v = 32'h09FB385B;   5'd3: v = 32'h051111D4;
            5'd4: v = 32'h028B0D43;   5'd5: v = 32'h0145D7E1;
            5'd6: v = 32'h00A2F61E;   5'd7: v = 32'h00517C55;
            5'd8: v = 32'h0028BE53;   5'd9: v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
         endcase
         return v;
      end
   endfunction

endpackage

`default_nettype wire

// ----- rtl/arc_vertex_generator_unit.sv -----
// ---------------------------------------------------------------------------
// arc_vertex_generator_unit
// Arc and circle tessellator: optional centre vertex, rotated perimeter vertices,
// optional closing vertex.
// ---------------------------------------------------------------------------
//  channel   ports                       transfer when
//  request   start, busy, req_*          start && !busy
//  result    rsp_valid, rsp_*            rsp_valid (one cycle, no stall)
//
//  Setup runs an 11-step root (automatic count only), a 33-step radix-2
//  divider and two 30-step CORDIC runs on one shared unit.
//  Each perimeter vertex but the last then needs eight products
//  through the single 33x25 multiplier, accumulation and the rotation update.
//  Busy also covers the centre and closing vertex; each result is registered and
//  shows in the cycle after its state, so the final vertex appears in the first
//  idle cycle.
//  Synchronous active-high reset returns to idle with no result pending.
//  Results cannot be held off by the receiver.
// ---------------------------------------------------------------------------
`default_nettype none

module arc_vertex_generator_unit (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire signed [23:0]  req_centre_x,
   input  wire signed [23:0]  req_centre_y,
   input  wire        [22:0]  req_radius,
   input  wire        [15:0]  req_start_angle,
   input  wire        [15:0]  req_end_angle,
   input  wire        [5:0]   req_segments,
   input  wire                req_include_centre,
   input  wire                req_close_loop,
   output logic               rsp_valid,
   output logic signed [23:0] rsp_vertex_x,
   output logic signed [23:0] rsp_vertex_y,
   output logic               rsp_last
);

   avg_pkg::cmd_type    cmd;
   avg_pkg::status_type status;

   avg_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   avg_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_centre_x       (req_centre_x),
      .req_centre_y       (req_centre_y),
      .req_radius         (req_radius),
      .req_start_angle    (req_start_angle),
      .req_end_angle      (req_end_angle),
      .req_segments       (req_segments),
      .req_include_centre (req_include_centre),
      .req_close_loop     (req_close_loop),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_vertex_x       (rsp_vertex_x),
      .rsp_vertex_y       (rsp_vertex_y),
      .rsp_last           (rsp_last)
   );

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request transfer did not raise busy");

   a_rsp_in_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result outside a request");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result after final vertex");
`endif

endmodule

`default_nettype wire

// ----- rtl/avg_datapath.sv -----
// ---------------------------------------------------------------------------
// avg_datapath
// Operand registers, shared multiplier, root, divider, CORDIC and rotation.
// ---------------------------------------------------------------------------
`default_nettype none

module avg_datapath (
   input  wire                   clock,
   input  wire                   reset,
   input  avg_pkg::cmd_type      cmd,
   input  wire signed [23:0]     req_centre_x,
   input  wire signed [23:0]     req_centre_y,
   input  wire        [22:0]     req_radius,
   input  wire        [15:0]     req_start_angle,
   input  wire        [15:0]     req_end_angle,
   input  wire        [5:0]      req_segments,
   input  wire                   req_include_centre,
   input  wire                   req_close_loop,
   output avg_pkg::status_type   status,
   output logic                  rsp_valid,
   output logic signed [23:0]    rsp_vertex_x,
   output logic signed [23:0]    rsp_vertex_y,
   output logic                  rsp_last
);

   function automatic logic signed [39:0] sat40(input logic signed [43:0] v);
      logic signed [39:0] r;
      begin
         if (v > 44'sh007FFFFFFFFF)       r = 40'sh7FFFFFFFFF;
         else if (v < -44'sh008000000000) r = -40'sh8000000000;
         else                             r = v[39:0];
         return r;
      end
   endfunction

   function automatic logic signed [23:0] mk_coord(input logic signed [23:0] c,
                                                   input logic signed [39:0] r);
      logic signed [40:0] rr;
      logic signed [25:0] s;
      logic signed [23:0] o;
      begin
         rr = {r[39], r} + 41'sd32768;
         s  = {{2{c[23]}}, c} + {rr[40], rr[40:16]};
         if (s > 26'sd8388607)       o = 24'sh7FFFFF;
         else if (s < -26'sd8388608) o = -24'sh800000;
         else                        o = s[23:0];
         return o;
      end
   endfunction

   // request
   logic signed [23:0] cx_ff, cy_ff;
   logic [22:0] radius_ff;
   logic [15:0] start_ff;
   logic [16:0] arc_ff;
   logic [5:0]  segs_in_ff;
   logic        incl_ff, loop_ff;
   logic [16:0] arc_in;
   logic [15:0] angle_diff;

   // multiplier
   logic signed [32:0] mul_a;
   logic signed [24:0] mul_b;
   logic signed [57:0] prod_ff;

   // root
   logic [21:0] sq_q_ff;
   logic [12:0] sq_rem_ff;
   logic [11:0] sq_res_ff;
   logic [21:0] sq_shift;
   logic [14:0] sq_cat;
   logic [13:0] sq_trial;
   logic [11:0] n_ceil;
   logic [30:0] q_sum;

   // divider
   logic [5:0]  segs_ff;
   logic [32:0] div_num_ff;
   logic [5:0]  div_rem_ff;
   logic [6:0]  div_sh;
   logic [12:0] seg_auto;
   logic [5:0]  seg_pick;

   // CORDIC
   logic signed [33:0] cor_x_ff, cor_y_ff;
   logic signed [32:0] cor_z_ff;
   logic [1:0]  cor_q_ff;
   logic [31:0] cor_angle;
   logic signed [33:0] cor_xs, cor_ys, fold_c, fold_s;
   logic signed [32:0] cor_atan;
   logic signed [31:0] step_cos_ff, step_sin_ff, c0_ff, s0_ff;

   // rotation
   logic signed [39:0] rot_x_ff, rot_y_ff;
   logic signed [73:0] acc_x_ff, acc_y_ff, term;
   logic [2:0]  mt, pt;
   logic signed [31:0] coef;
   logic signed [39:0] rsrc;
   logic signed [57:0] rnd_r;
   logic signed [73:0] fin_x, fin_y;

   // output
   logic signed [23:0] first_x_ff, first_y_ff, vx, vy;
   logic        first_ff;
   logic        rsp_valid_ff, rsp_last_ff;
   logic signed [23:0] rsp_x_ff, rsp_y_ff;

   assign angle_diff = req_end_angle - req_start_angle;
   assign arc_in     = (angle_diff == 16'd0) ? 17'h10000 : {1'b0, angle_diff};

   assign sq_shift = sq_q_ff >> {cmd.idx[3:0], 1'b0};
   assign sq_cat   = {sq_rem_ff, sq_shift[1:0]};
   assign sq_trial = {sq_res_ff, 2'b01};
   assign n_ceil   = sq_res_ff + {11'd0, (sq_rem_ff != 13'd0)};
   assign q_sum    = prod_ff[30:0] + 31'd255;

   assign div_sh   = {div_rem_ff, div_num_ff[32]};
   assign seg_auto = prod_ff[28:16];

   always_comb begin
      if (segs_in_ff == 6'd0) begin
         if (seg_auto == 13'd0) seg_pick = 6'd1;
         else if (seg_auto > 13'(avg_pkg::MaxSegments))
            seg_pick = 6'(avg_pkg::MaxSegments);
         else seg_pick = seg_auto[5:0];
      end else if (segs_in_ff > 6'(avg_pkg::MaxSegments)) begin
         seg_pick = 6'(avg_pkg::MaxSegments);
      end else begin
         seg_pick = segs_in_ff;
      end
   end

   assign cor_angle = (cmd.op == avg_pkg::OP_CINIT_STEP) ? div_num_ff[31:0]
                                                         : {start_ff, 16'd0};
   assign cor_xs   = cor_x_ff >>> cmd.idx[4:0];
   assign cor_ys   = cor_y_ff >>> cmd.idx[4:0];
   assign cor_atan = $signed({1'b0, avg_pkg::atan_turn(cmd.idx[4:0])});

   always_comb begin
      unique case (cor_q_ff)
         2'd0: begin fold_c = cor_x_ff;  fold_s = cor_y_ff;  end
         2'd1: begin fold_c = -cor_y_ff; fold_s = cor_x_ff;  end
         2'd2: begin fold_c = -cor_x_ff; fold_s = -cor_y_ff; end
         default: begin fold_c = cor_y_ff; fold_s = -cor_x_ff; end
      endcase
   end

   // rotation terms: c*xh, c*xl, -s*yh, -s*yl, s*xh, s*xl, c*yh, c*yl
   assign mt   = cmd.idx[2:0];
   assign pt   = 3'(cmd.idx - 6'd1);
   assign coef = (mt[1] ^ mt[2]) ? step_sin_ff : step_cos_ff;
   assign rsrc = mt[1] ? rot_y_ff : rot_x_ff;

   always_comb begin
      mul_a = 33'sd0;
      mul_b = 25'sd0;
      unique case (cmd.op)
         avg_pkg::OP_MUL100: begin
            mul_a = 33'sd100;
            mul_b = $signed({2'b00, radius_ff});
         end
         avg_pkg::OP_MULN: begin
            mul_a = $signed({16'd0, arc_ff});
            mul_b = $signed({13'd0, n_ceil});
         end
         avg_pkg::OP_MULRX: begin
            mul_a = {c0_ff[31], c0_ff};
            mul_b = $signed({2'b00, radius_ff});
         end
         avg_pkg::OP_MULRY: begin
            mul_a = {s0_ff[31], s0_ff};
            mul_b = $signed({2'b00, radius_ff});
         end
         avg_pkg::OP_MAC: begin
            mul_a = {coef[31], coef};
            mul_b = mt[0] ? $signed({9'd0, rsrc[15:0]})
                          : $signed({rsrc[39], rsrc[39:16]});
         end
         default: begin
            mul_a = 33'sd0;
            mul_b = 25'sd0;
         end
      endcase
   end

   assign term  = pt[0] ? {{16{prod_ff[57]}}, prod_ff} : {prod_ff, 16'd0};
   assign rnd_r = prod_ff + 58'sd8192;
   assign fin_x = acc_x_ff + 74'sd536870912;
   assign fin_y = acc_y_ff + 74'sd536870912;

   assign vx = mk_coord(cx_ff, rot_x_ff);
   assign vy = mk_coord(cy_ff, rot_y_ff);

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      unique case (cmd.op)
         avg_pkg::OP_LOAD: begin
            cx_ff      <= req_centre_x;
            cy_ff      <= req_centre_y;
            radius_ff  <= req_radius;
            start_ff   <= req_start_angle;
            arc_ff     <= arc_in;
            segs_in_ff <= req_segments;
            incl_ff    <= req_include_centre;
            loop_ff    <= req_close_loop;
         end
         avg_pkg::OP_QLOAD: begin
            sq_q_ff   <= q_sum[29:8];
            sq_rem_ff <= 13'd0;
            sq_res_ff <= 12'd0;
         end
         avg_pkg::OP_SQRT: begin
            if ({1'b0, sq_cat} >= {2'b00, sq_trial}) begin
               sq_rem_ff <= 13'({1'b0, sq_cat} - {2'b00, sq_trial});
               sq_res_ff <= {sq_res_ff[10:0], 1'b1};
            end else begin
               sq_rem_ff <= sq_cat[12:0];
               sq_res_ff <= {sq_res_ff[10:0], 1'b0};
            end
         end
         avg_pkg::OP_SEGS: segs_ff <= seg_pick;
         avg_pkg::OP_DIVINIT: begin
            div_num_ff <= {arc_ff, 16'd0} + {28'd0, segs_ff[5:1]};
            div_rem_ff <= 6'd0;
         end
         avg_pkg::OP_DIV: begin
            if (div_sh >= {1'b0, segs_ff}) begin
               div_rem_ff <= 6'(div_sh - {1'b0, segs_ff});
               div_num_ff <= {div_num_ff[31:0], 1'b1};
            end else begin
               div_rem_ff <= div_sh[5:0];
               div_num_ff <= {div_num_ff[31:0], 1'b0};
            end
         end
         avg_pkg::OP_CINIT_STEP, avg_pkg::OP_CINIT_START: begin
            cor_q_ff <= cor_angle[31:30];
            cor_z_ff <= $signed({3'b000, cor_angle[29:0]});
            cor_x_ff <= avg_pkg::CordicGain;
            cor_y_ff <= 34'sd0;
         end
         avg_pkg::OP_CORDIC: begin
            if (!cor_z_ff[32]) begin
               cor_x_ff <= cor_x_ff - cor_ys;
               cor_y_ff <= cor_y_ff + cor_xs;
               cor_z_ff <= cor_z_ff - cor_atan;
            end else begin
               cor_x_ff <= cor_x_ff + cor_ys;
               cor_y_ff <= cor_y_ff - cor_xs;
               cor_z_ff <= cor_z_ff + cor_atan;
            end
         end
         avg_pkg::OP_CSTORE_STEP: begin
            step_cos_ff <= fold_c[31:0];
            step_sin_ff <= fold_s[31:0];
         end
         avg_pkg::OP_CSTORE_START: begin
            c0_ff <= fold_c[31:0];
            s0_ff <= fold_s[31:0];
         end
         avg_pkg::OP_ROTX: rot_x_ff <= sat40(rnd_r[57:14]);
         avg_pkg::OP_ROTY: rot_y_ff <= sat40(rnd_r[57:14]);
         avg_pkg::OP_VERTEX: begin
            segs_ff <= segs_ff - 6'd1;
            if (first_ff) begin
               first_x_ff <= vx;
               first_y_ff <= vy;
            end
         end
         avg_pkg::OP_MAC: begin
            if (cmd.idx == 6'd0) begin
               acc_x_ff <= 74'sd0;
               acc_y_ff <= 74'sd0;
            end else if (!pt[2]) begin
               acc_x_ff <= pt[1] ? acc_x_ff - term : acc_x_ff + term;
            end else begin
               acc_y_ff <= acc_y_ff + term;
            end
         end
         avg_pkg::OP_ROTUPD: begin
            rot_x_ff <= sat40(fin_x[73:30]);
            rot_y_ff <= sat40(fin_y[73:30]);
         end
         default: begin
         end
      endcase
   end

   // first-vertex flag and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (cmd.op)
            avg_pkg::OP_LOAD: first_ff <= 1'b1;
            avg_pkg::OP_CENTRE: begin
               rsp_valid_ff <= 1'b1;
               rsp_x_ff     <= cx_ff;
               rsp_y_ff     <= cy_ff;
               rsp_last_ff  <= 1'b0;
            end
            avg_pkg::OP_VERTEX: begin
               first_ff     <= 1'b0;
               rsp_valid_ff <= 1'b1;
               rsp_x_ff     <= vx;
               rsp_y_ff     <= vy;
               rsp_last_ff  <= (segs_ff == 6'd1) && !loop_ff;
            end
            avg_pkg::OP_LOOP: begin
               rsp_valid_ff <= 1'b1;
               rsp_x_ff     <= first_x_ff;
               rsp_y_ff     <= first_y_ff;
               rsp_last_ff  <= 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign status.auto_seg       = (segs_in_ff == 6'd0);
   assign status.include_centre = incl_ff;
   assign status.close_loop     = loop_ff;
   assign status.left_one       = (segs_ff == 6'd1);

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_vertex_x = rsp_x_ff;
   assign rsp_vertex_y = rsp_y_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire

// ----- rtl/avg_controller.sv -----
// ---------------------------------------------------------------------------
// avg_controller
// Sequencer: setup phases, per-vertex loop and iteration counter.
// ---------------------------------------------------------------------------
`default_nettype none

module avg_controller (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  avg_pkg::status_type  status,
   output avg_pkg::cmd_type     cmd,
   output logic                 busy
);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_MUL100 = 5'd1;
   localparam logic [4:0] S_QLOAD  = 5'd2;
   localparam logic [4:0] S_SQRT   = 5'd3;
   localparam logic [4:0] S_MULN   = 5'd4;
   localparam logic [4:0] S_SEGS   = 5'd5;
   localparam logic [4:0] S_DIVINI = 5'd6;
   localparam logic [4:0] S_DIV    = 5'd7;
   localparam logic [4:0] S_CINIA  = 5'd8;
   localparam logic [4:0] S_CORA   = 5'd9;
   localparam logic [4:0] S_CSTA   = 5'd10;
   localparam logic [4:0] S_CINIB  = 5'd11;
   localparam logic [4:0] S_CORB   = 5'd12;
   localparam logic [4:0] S_CSTB   = 5'd13;
   localparam logic [4:0] S_MULRX  = 5'd14;
   localparam logic [4:0] S_ROTX   = 5'd15;
   localparam logic [4:0] S_MULRY  = 5'd16;
   localparam logic [4:0] S_ROTY   = 5'd17;
   localparam logic [4:0] S_CENTRE = 5'd18;
   localparam logic [4:0] S_VERTEX = 5'd19;
   localparam logic [4:0] S_MAC    = 5'd20;
   localparam logic [4:0] S_ROTUPD = 5'd21;
   localparam logic [4:0] S_LOOP   = 5'd22;

   localparam logic [5:0] SqrtLast = 6'd10;
   localparam logic [5:0] DivLast  = 6'd32;
   localparam logic [5:0] CorLast  = 6'(avg_pkg::CordicSteps - 1);
   localparam logic [5:0] MacLast  = 6'd8;

   logic [4:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd.op   = avg_pkg::OP_NOP;
      cmd.idx  = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = avg_pkg::OP_LOAD;
               state_in = S_MUL100;
            end
         end
         S_MUL100: begin
            cmd.op   = avg_pkg::OP_MUL100;
            state_in = status.auto_seg ? S_QLOAD : S_SEGS;
         end
         S_QLOAD: begin
            cmd.op   = avg_pkg::OP_QLOAD;
            cnt_in   = SqrtLast;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = avg_pkg::OP_SQRT;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) state_in = S_MULN;
         end
         S_MULN: begin
            cmd.op   = avg_pkg::OP_MULN;
            state_in = S_SEGS;
         end
         S_SEGS: begin
            cmd.op   = avg_pkg::OP_SEGS;
            state_in = S_DIVINI;
         end
         S_DIVINI: begin
            cmd.op   = avg_pkg::OP_DIVINIT;
            cnt_in   = DivLast;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = avg_pkg::OP_DIV;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) state_in = S_CINIA;
         end
         S_CINIA: begin
            cmd.op   = avg_pkg::OP_CINIT_STEP;
            cnt_in   = 6'd0;
            state_in = S_CORA;
         end
         S_CORA: begin
            cmd.op = avg_pkg::OP_CORDIC;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == CorLast) state_in = S_CSTA;
         end
         S_CSTA: begin
            cmd.op   = avg_pkg::OP_CSTORE_STEP;
            state_in = S_CINIB;
         end
         S_CINIB: begin
            cmd.op   = avg_pkg::OP_CINIT_START;
            cnt_in   = 6'd0;
            state_in = S_CORB;
         end
         S_CORB: begin
            cmd.op = avg_pkg::OP_CORDIC;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == CorLast) state_in = S_CSTB;
         end
         S_CSTB: begin
            cmd.op   = avg_pkg::OP_CSTORE_START;
            state_in = S_MULRX;
         end
         S_MULRX: begin
            cmd.op   = avg_pkg::OP_MULRX;
            state_in = S_ROTX;
         end
         S_ROTX: begin
            cmd.op   = avg_pkg::OP_ROTX;
            state_in = S_MULRY;
         end
         S_MULRY: begin
            cmd.op   = avg_pkg::OP_MULRY;
            state_in = S_ROTY;
         end
         S_ROTY: begin
            cmd.op   = avg_pkg::OP_ROTY;
            state_in = status.include_centre ? S_CENTRE : S_VERTEX;
         end
         S_CENTRE: begin
            cmd.op   = avg_pkg::OP_CENTRE;
            state_in = S_VERTEX;
         end
         S_VERTEX: begin
            cmd.op = avg_pkg::OP_VERTEX;
            cnt_in = 6'd0;
            // the final perimeter vertex needs no further rotation
            if (status.left_one) state_in = status.close_loop ? S_LOOP : S_IDLE;
            else                 state_in = S_MAC;
         end
         S_MAC: begin
            cmd.op = avg_pkg::OP_MAC;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == MacLast) state_in = S_ROTUPD;
         end
         S_ROTUPD: begin
            cmd.op   = avg_pkg::OP_ROTUPD;
            state_in = S_VERTEX;
         end
         S_LOOP: begin
            cmd.op   = avg_pkg::OP_LOOP;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 6'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire
